[rtl/core/nrmc_pkg.sv]
`default_nettype none

package nrmc_pkg;

	// Fraction digits of the minutes text that are kept.
	localparam int FRAC_DIGITS = 5;
	localparam logic [2:0] FRAC_CNT = 3'(FRAC_DIGITS);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_NOT_RMC    = 2'd0,
		ST_VOID       = 2'd1,
		ST_FIX_OK     = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	// Widths of the parsed number and of the conversion path.
	localparam int INT_W  = 15;   // integer part ddmm, saturated at INT_CAP
	localparam int F7_W   = 24;   // fraction of a minute in units of 1e-7
	localparam int DEG_W  = 8;    // whole degrees, at most 180
	localparam int MIN_W  = 7;    // whole minutes
	localparam int X_W    = 30;   // minutes in 1e-7 units plus rounding bias
	localparam int PART_W = 25;   // minutes converted to 1e-7 degree
	localparam int MAG_W  = 31;   // saturated magnitude
	localparam int VAL_W  = 32;   // signed result

	// An integer part of 18000 already means 180 degrees, which every limit caps.
	localparam logic [INT_W-1:0] INT_CAP = 15'd18000;

	// Reciprocal constants: floor(v/100) for v <= 18000 and floor(y/15) for y < 2^28.
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [28:0] DIV15_MUL    = 29'd286331154;
	localparam int          DIV15_SHIFT  = 32;

	localparam logic [23:0] DEG_SCALE  = 24'd10000000;
	localparam logic [4:0]  ROUND_BIAS = 5'd30;

	localparam logic [MAG_W-1:0] LAT_LIMIT = 31'd900000000;
	localparam logic [MAG_W-1:0] LON_LIMIT = 31'd1800000000;

	// Registered stages from the parse register to the output register.
	localparam int PIPE_LEN = 7;

	// One coordinate handed to a conversion lane.
	typedef struct packed {
		logic [INT_W-1:0] whole;
		logic [F7_W-1:0]  frac7;
		logic             neg;
	} lane_in_t;

endpackage

`default_nettype wire

[rtl/core/nrmc_lane.sv]
`default_nettype none

module nrmc_lane (
	input  wire logic                   clk,
	input  wire logic                   adv,
	input  wire nrmc_pkg::lane_in_t     lane_in,
	input  wire logic [30:0]            limit,
	output logic      [31:0]            value
);
	import nrmc_pkg::*;

	logic [INT_W-1:0]    whole_s2;
	logic [F7_W-1:0]     frac7_s2, frac7_s3;
	logic [DEG_W-1:0]    deg_s2, deg_s3, deg_s4, deg_s5;
	logic [MIN_W-1:0]    minute_s3;
	logic [X_W-1:0]      x_s4;
	logic [PART_W-1:0]   part_s5;
	logic [MAG_W-1:0]    mag_s6;
	logic                neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;

	logic [27:0]         p100;
	logic [INT_W-1:0]    minute_full;
	logic [X_W-1:0]      x_sum;
	logic [56:0]         p15;
	logic [31:0]         total;

	// Whole degrees by reciprocal multiplication.
	assign p100 = 28'(lane_in.whole) * 28'(DIV100_MUL);

	// Whole minutes are what is left over after the degrees.
	assign minute_full = whole_s2 - INT_W'(deg_s2) * INT_W'(7'd100);

	// Minutes in units of 1e-7 minute, with the bias that rounds halves up.
	assign x_sum = X_W'(minute_s3) * X_W'(DEG_SCALE) + X_W'(frac7_s3) + X_W'(ROUND_BIAS);

	// Divide by 60: drop two bits, then multiply by the reciprocal of 15.
	assign p15 = 57'(x_s4[X_W-1:2]) * 57'(DIV15_MUL);

	assign total = 32'(deg_s5) * 32'(DEG_SCALE) + 32'(part_s5);

	// Conversion pipeline; every stage moves together with the block's pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			whole_s2  <= lane_in.whole;
			frac7_s2  <= lane_in.frac7;
			deg_s2    <= p100[DIV100_SHIFT +: DEG_W];
			neg_s2    <= lane_in.neg;

			minute_s3 <= minute_full[MIN_W-1:0];
			frac7_s3  <= frac7_s2;
			deg_s3    <= deg_s2;
			neg_s3    <= neg_s2;

			x_s4      <= x_sum;
			deg_s4    <= deg_s3;
			neg_s4    <= neg_s3;

			part_s5   <= p15[DIV15_SHIFT +: PART_W];
			deg_s5    <= deg_s4;
			neg_s5    <= neg_s4;

			mag_s6    <= (total > 32'(limit)) ? limit : total[MAG_W-1:0];
			neg_s6    <= neg_s5;

			value     <= neg_s6 ? (32'd0 - 32'(mag_s6)) : 32'(mag_s6);
		end
	end

endmodule

`default_nettype wire

[rtl/core/nmea_rmc_position_parser.sv]
// Parses NMEA 0183 RMC sentences fed one byte per word on the slave stream
// (tuser marks the first byte, tlast the final byte) and gives one result word
// per sentence on the master stream: status 0 not RMC, 1 void fix, 2 fix ok,
// 3 incomplete, plus latitude and longitude in 1e-7 degree, valid with fix ok
// and zero otherwise. A byte is taken every cycle; tready drops only while a
// finished result waits at the output. The result of the byte that decides the
// sentence is registered beside the byte parser, then runs through the
// pipelined degree/minute conversion lanes to the output register.
// Bytes outside an open sentence produce nothing, and a new first byte drops
// any open sentence without a result.

`default_nettype none

module nmea_rmc_position_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	input  wire logic        s_tuser,   // [0] first
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata    // [1:0] status, [32:2] latitude, [64:33] longitude
);
	import nrmc_pkg::*;

	localparam logic [2:0] HDR_LEN   = 3'd6;
	localparam logic [2:0] FLD_VALID = 3'd2;
	localparam logic [2:0] FLD_LAT   = 3'd3;
	localparam logic [2:0] FLD_NS    = 3'd4;
	localparam logic [2:0] FLD_LON   = 3'd5;
	localparam logic [2:0] FLD_EW    = 3'd6;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h24; // '$'
			3'd1:    ch = 8'h47; // 'G'
			3'd2:    ch = 8'h50; // 'P'
			3'd3:    ch = 8'h52; // 'R'
			3'd4:    ch = 8'h4D; // 'M'
			3'd5:    ch = 8'h43; // 'C'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// True when the first byte of a field is the letter that field looks for.
	function automatic logic letter_match(input logic [2:0] fld, input logic [7:0] ch);
		logic hit;
		unique case (fld)
			FLD_VALID: hit = (ch == 8'h41); // 'A'
			FLD_NS:    hit = (ch == 8'h53); // 'S'
			FLD_EW:    hit = (ch == 8'h57); // 'W'
			default:   hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Weight of a fraction digit in 1e-7 minute.
	function automatic logic [19:0] frac_weight(input logic [2:0] idx);
		logic [19:0] w;
		unique case (idx)
			3'd0:    w = 20'd1000000;
			3'd1:    w = 20'd100000;
			3'd2:    w = 20'd10000;
			3'd3:    w = 20'd1000;
			3'd4:    w = 20'd100;
			3'd5:    w = 20'd10;
			3'd6:    w = 20'd1;
			default: w = 20'd0;
		endcase
		return w;
	endfunction

	// Parser state.
	logic [2:0]       hdr_q, cc_q, fc_q;
	logic             afs_q, ff_q, pt_q, end_q, done_q;
	logic [INT_W-1:0] whole_q, lat_whole_q, lon_whole_q;
	logic [F7_W-1:0]  frac7_q, lat_frac7_q, lon_frac7_q;
	logic             lat_neg_q;

	logic [2:0]       hdr_d, cc_d, fc_d, hdr_b, cc_b, fc_b;
	logic             afs_d, ff_d, pt_d, end_d, done_d;
	logic             afs_b, ff_b, pt_b, end_b, ff_w;
	logic [INT_W-1:0] whole_d, whole_b, lat_whole_d, lon_whole_d;
	logic [F7_W-1:0]  frac7_d, frac7_b, lat_frac7_d, lon_frac7_d;
	logic             lat_neg_d, lon_neg_w;
	logic             emit, open;
	status_t          sts;
	logic [3:0]       digit;
	logic [18:0]      whole_x;

	// Pipeline control and payload.
	logic                adv, s_acc;
	logic [PIPE_LEN-1:0] vld_q;
	status_t             sts_q [PIPE_LEN];
	lane_in_t            lat_s1, lon_s1;
	logic [31:0]         lat_val, lon_val;

	assign adv      = ~m_tvalid | m_tready;
	assign s_tready = adv;
	assign s_acc    = s_tvalid & s_tready;
	assign m_tvalid = vld_q[PIPE_LEN-1];
	assign m_tdata  = {7'd0, lon_val, lat_val[30:0], sts_q[PIPE_LEN-1]};

	assign digit   = 4'(s_tdata - CH_ZERO);
	assign whole_x = 19'(whole_b) * 19'd10 + 19'(digit);

	// Next parser state for the byte on the input.
	always_comb begin
		open  = s_tuser | ~done_q;
		hdr_b   = s_tuser ? 3'd0 : hdr_q;
		cc_b    = s_tuser ? 3'd0 : cc_q;
		afs_b   = s_tuser ? 1'b0 : afs_q;
		ff_b    = s_tuser ? 1'b0 : ff_q;
		whole_b = s_tuser ? '0 : whole_q;
		frac7_b = s_tuser ? '0 : frac7_q;
		fc_b    = s_tuser ? 3'd0 : fc_q;
		pt_b    = s_tuser ? 1'b0 : pt_q;
		end_b   = s_tuser ? 1'b0 : end_q;

		hdr_d   = hdr_b;
		cc_d    = cc_b;
		afs_d   = afs_b;
		ff_d    = ff_b;
		whole_d = whole_b;
		frac7_d = frac7_b;
		fc_d    = fc_b;
		pt_d    = pt_b;
		end_d   = end_b;
		done_d  = s_tuser ? 1'b0 : done_q;
		lat_whole_d = lat_whole_q;
		lat_frac7_d = lat_frac7_q;
		lon_whole_d = lon_whole_q;
		lon_frac7_d = lon_frac7_q;
		lat_neg_d   = lat_neg_q;
		ff_w      = ff_b;
		lon_neg_w = 1'b0;
		emit      = 1'b0;
		sts       = ST_NOT_RMC;

		if (open) begin
			if (hdr_b < HDR_LEN) begin
				// Header match.
				if (s_tdata != hdr_char(hdr_b)) begin
					emit = 1'b1;
					sts  = ST_NOT_RMC;
				end else begin
					hdr_d = hdr_b + 3'd1;
					if (s_tlast && (hdr_b + 3'd1 < HDR_LEN)) begin
						emit = 1'b1;
						sts  = ST_NOT_RMC;
					end
				end
			end else begin
				if (afs_b) begin
					ff_w  = letter_match(cc_b, s_tdata);
					afs_d = 1'b0;
				end
				ff_d = ff_w;
				if (s_tdata == CH_COMMA) begin
					// A comma closes the current field.
					unique case (cc_b)
						FLD_VALID: begin
							if (!ff_w) begin
								emit = 1'b1;
								sts  = ST_VOID;
							end
						end
						FLD_LAT: begin
							lat_whole_d = whole_b;
							lat_frac7_d = frac7_b;
						end
						FLD_NS: begin
							lat_neg_d = ff_w;
						end
						FLD_LON: begin
							lon_whole_d = whole_b;
							lon_frac7_d = frac7_b;
						end
						FLD_EW: begin
							lon_neg_w = ff_w;
							emit      = 1'b1;
							sts       = ST_FIX_OK;
						end
						default: begin
						end
					endcase
					if (!emit) begin
						cc_d    = cc_b + 3'd1;
						afs_d   = 1'b1;
						whole_d = '0;
						frac7_d = '0;
						fc_d    = 3'd0;
						pt_d    = 1'b0;
						end_d   = 1'b0;
					end
				end else if ((cc_b == FLD_LAT || cc_b == FLD_LON) && !end_b) begin
					// Number text: digits, one point, then fraction digits.
					if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
						if (!pt_b) begin
							whole_d = (whole_x >= 19'(INT_CAP)) ? INT_CAP : whole_x[INT_W-1:0];
						end else if (fc_b < FRAC_CNT) begin
							frac7_d = frac7_b + F7_W'(digit) * F7_W'(frac_weight(fc_b));
							fc_d    = fc_b + 3'd1;
						end
					end else if (s_tdata == CH_POINT && !pt_b) begin
						pt_d = 1'b1;
					end else begin
						end_d = 1'b1;
					end
				end
				if (!emit && s_tlast) begin
					emit = 1'b1;
					sts  = ST_INCOMPLETE;
				end
			end
		end
		if (emit) begin
			done_d = 1'b1;
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= 3'd0;
			cc_q        <= 3'd0;
			afs_q       <= 1'b0;
			ff_q        <= 1'b0;
			whole_q     <= '0;
			frac7_q     <= '0;
			fc_q        <= 3'd0;
			pt_q        <= 1'b0;
			end_q       <= 1'b0;
			done_q      <= 1'b1;
			lat_whole_q <= '0;
			lat_frac7_q <= '0;
			lon_whole_q <= '0;
			lon_frac7_q <= '0;
			lat_neg_q   <= 1'b0;
		end else if (s_acc) begin
			hdr_q       <= hdr_d;
			cc_q        <= cc_d;
			afs_q       <= afs_d;
			ff_q        <= ff_d;
			whole_q     <= whole_d;
			frac7_q     <= frac7_d;
			fc_q        <= fc_d;
			pt_q        <= pt_d;
			end_q       <= end_d;
			done_q      <= done_d;
			lat_whole_q <= lat_whole_d;
			lat_frac7_q <= lat_frac7_d;
			lon_whole_q <= lon_whole_d;
			lon_frac7_q <= lon_frac7_d;
			lat_neg_q   <= lat_neg_d;
		end
	end

	// Valid bits of the result pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], s_acc & emit};
		end
	end

	// Status travels beside the conversion lanes; results other than a fix
	// feed zeros, which convert to zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			sts_q[0] <= sts;
			for (int i = 1; i < PIPE_LEN; i++) begin
				sts_q[i] <= sts_q[i-1];
			end
			if (sts == ST_FIX_OK) begin
				lat_s1 <= '{whole: lat_whole_q, frac7: lat_frac7_q, neg: lat_neg_q};
				lon_s1 <= '{whole: lon_whole_q, frac7: lon_frac7_q, neg: lon_neg_w};
			end else begin
				lat_s1 <= '0;
				lon_s1 <= '0;
			end
		end
	end

	nrmc_lane u_lat_lane (
		.clk     (clk),
		.adv     (adv),
		.lane_in (lat_s1),
		.limit   (LAT_LIMIT),
		.value   (lat_val)
	);

	nrmc_lane u_lon_lane (
		.clk     (clk),
		.adv     (adv),
		.lane_in (lon_s1),
		.limit   (LON_LIMIT),
		.value   (lon_val)
	);

endmodule

`default_nettype wire

[tb/sv/rmc_fix_checker.sv]
// Watches both streams of the RMC position parser. Every byte word taken on the
// slave side runs through a copy of the sentence parser kept here; every result
// word taken on the master side is compared with the oldest predicted result.
module rmc_fix_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	input  wire logic        s_tuser,   // [0] first
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,   // [1:0] status, [32:2] latitude, [64:33] longitude
	output int               errors,
	output int               pending
);
	import nrmc_pkg::*;

	typedef struct {
		status_t     status;
		logic [30:0] lat;
		logic [31:0] lon;
	} fix_report_t;

	// Sentence header and the characters that steer the field parse.
	localparam logic [47:0] RMC_TAG  = "$GPRMC";
	localparam logic [7:0]  CH_COMMA = ",";
	localparam logic [7:0]  CH_POINT = ".";
	localparam logic [7:0]  CH_VALID = "A";
	localparam logic [7:0]  CH_SOUTH = "S";
	localparam logic [7:0]  CH_WEST  = "W";

	// Field numbers, counted in commas after the header.
	localparam logic [2:0] FLD_VALID = 3'd2;
	localparam logic [2:0] FLD_LAT   = 3'd3;
	localparam logic [2:0] FLD_NS    = 3'd4;
	localparam logic [2:0] FLD_LON   = 3'd5;
	localparam logic [2:0] FLD_EW    = 3'd6;

	localparam longint unsigned DEG_UNIT = 64'd10000000;
	localparam longint unsigned LAT_MAX  = 64'd900000000;
	localparam longint unsigned LON_MAX  = 64'd1800000000;

	// Parser copy.
	logic [2:0]  hdr_matched;
	logic [2:0]  comma_cnt;
	logic        field_start;
	logic        field_match;
	logic [63:0] accum;
	logic [2:0]  frac_taken;
	logic        point_seen;
	logic        num_stopped;
	logic [31:0] lat_deg;
	logic [31:0] lon_deg;
	logic        line_closed;

	fix_report_t expected_fixes[$];
	fix_report_t want;
	fix_report_t fresh;
	logic        produced;
	int          fail_cnt = 0;

	function automatic longint unsigned pow10(int n);
		longint unsigned p;
		p = 1;
		for (int k = 0; k < n; k++)
			p = p * 10;
		return p;
	endfunction

	// Splits ddmm.mmmmm into degrees and minutes and scales to 1e-7 degree,
	// rounding the minutes part to nearest with halves up and capping at the limit.
	function automatic logic [31:0] minutes_to_degrees(longint unsigned v,
			longint unsigned limit);
		longint unsigned scale;
		longint unsigned whole;
		longint unsigned rem;
		longint unsigned total;
		scale = pow10(FRAC_DIGITS);
		whole = v / (100 * scale);
		rem   = v % (100 * scale);
		total = whole * DEG_UNIT + (rem * DEG_UNIT + 30 * scale) / (60 * scale);
		if (total > limit)
			total = limit;
		return total[31:0];
	endfunction

	task automatic clear_number();
		accum       = '0;
		frac_taken  = '0;
		point_seen  = 1'b0;
		num_stopped = 1'b0;
	endtask

	task automatic restart_sentence();
		hdr_matched = '0;
		comma_cnt   = '0;
		field_start = 1'b0;
		field_match = 1'b0;
		clear_number();
		lat_deg     = '0;
		lon_deg     = '0;
	endtask

	// Advances the parser copy by one byte and says whether it decides the sentence.
	task automatic parse_sentence_byte(input logic [7:0] ch, input logic first_b,
			input logic last_b, output logic decided, output fix_report_t rep);
		status_t         st;
		logic [31:0]     lat_v;
		logic [31:0]     lon_v;
		longint unsigned acc;
		longint unsigned d;
		decided = 1'b0;
		st      = ST_NOT_RMC;
		lat_v   = '0;
		lon_v   = '0;
		rep     = '{ST_NOT_RMC, '0, '0};
		if (first_b) begin
			restart_sentence();
			line_closed = 1'b0;
		end
		if (!line_closed) begin
			if (hdr_matched < 3'd6) begin
				// Header bytes must spell the RMC tag in order.
				if (ch != RMC_TAG[47 - 8 * hdr_matched -: 8]) begin
					decided = 1'b1;
				end else begin
					hdr_matched = hdr_matched + 3'd1;
					if (last_b && hdr_matched < 3'd6)
						decided = 1'b1;
				end
			end else begin
				// The first byte of a flag field decides that field's letter match.
				if (field_start) begin
					case (comma_cnt)
						FLD_VALID: field_match = (ch == CH_VALID);
						FLD_NS:    field_match = (ch == CH_SOUTH);
						FLD_EW:    field_match = (ch == CH_WEST);
						default:   field_match = 1'b0;
					endcase
					field_start = 1'b0;
				end
				if (ch == CH_COMMA) begin
					case (comma_cnt)
						FLD_VALID: begin
							if (!field_match) begin
								decided = 1'b1;
								st      = ST_VOID;
							end
						end
						FLD_LAT: lat_deg = minutes_to_degrees(accum, LAT_MAX);
						FLD_NS: begin
							if (field_match)
								lat_deg = -lat_deg;
						end
						FLD_LON: lon_deg = minutes_to_degrees(accum, LON_MAX);
						FLD_EW: begin
							if (field_match)
								lon_deg = -lon_deg;
							decided = 1'b1;
							st      = ST_FIX_OK;
							lat_v   = lat_deg;
							lon_v   = lon_deg;
						end
						default: ;
					endcase
					if (!decided) begin
						comma_cnt   = comma_cnt + 3'd1;
						field_start = 1'b1;
						clear_number();
					end
				end else if ((comma_cnt == FLD_LAT || comma_cnt == FLD_LON) && !num_stopped) begin
					// Number text: digits, one point, fraction digits up to the kept count.
					if (ch >= "0" && ch <= "9") begin
						d   = 64'(ch - "0");
						acc = accum;
						if (!point_seen) begin
							acc = accum * 10 + d * pow10(FRAC_DIGITS);
						end else if (frac_taken < 3'(FRAC_DIGITS)) begin
							acc = accum + d * pow10(FRAC_DIGITS - int'(frac_taken) - 1);
							frac_taken = frac_taken + 3'd1;
						end
						if (acc > 100000 * pow10(FRAC_DIGITS))
							acc = 100000 * pow10(FRAC_DIGITS);
						accum = acc;
					end else if (ch == CH_POINT && !point_seen) begin
						point_seen = 1'b1;
					end else begin
						num_stopped = 1'b1;
					end
				end
				if (!decided && last_b) begin
					decided = 1'b1;
					st      = ST_INCOMPLETE;
				end
			end
			if (decided) begin
				line_closed = 1'b1;
				rep = '{st, lat_v[30:0], lon_v};
			end
		end
	endtask

	task automatic note_failure(input string msg);
		if (fail_cnt < 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fail_cnt++;
	endtask

	// Compare result words first, then predict from the byte word of the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_sentence();
			line_closed = 1'b1;
			expected_fixes.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_fixes.size() == 0) begin
					note_failure($sformatf("result word %h with no result expected", m_tdata));
				end else begin
					want = expected_fixes.pop_front();
					if (m_tdata[1:0] !== want.status || m_tdata[32:2] !== want.lat
							|| m_tdata[64:33] !== want.lon)
						note_failure($sformatf(
							"expected status %0d lat %0d lon %0d, got status %0d lat %0d lon %0d",
							want.status, $signed(want.lat), $signed(want.lon), m_tdata[1:0],
							$signed(m_tdata[32:2]), $signed(m_tdata[64:33])));
				end
			end
			if (s_tvalid && s_tready) begin
				parse_sentence_byte(s_tdata, s_tuser, s_tlast, produced, fresh);
				if (produced)
					expected_fixes.push_back(fresh);
			end
			pending <= expected_fixes.size();
			errors  <= fail_cnt;
		end
	end

endmodule

[tb/sv/tb_nmea_rmc_position_parser.sv]
// Stimulus and verdict for the RMC position parser: a short directed set of
// sentences, then random sentences that are mostly well formed, mixed with
// truncated sentences, corrupted headers and loose noise bytes.
module tb_nmea_rmc_position_parser;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       last;
	} byte_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_in
	logic        s_tuser  = 1'b0;    // [0] first
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;            // [1:0] status, [32:2] latitude, [64:33] longitude
	int          errors;
	int          pending;

	byte_word_t  stream[$];
	bit          calm = 1'b0;

	nmea_rmc_position_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rmc_fix_checker fix_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic string digits(int n);
		string txt;
		txt = "";
		for (int k = 0; k < n; k++)
			txt = {txt, $sformatf("%0d", $urandom_range(0, 9))};
		return txt;
	endfunction

	// Coordinate text, weighted toward limits, rounding edges and odd forms.
	function automatic string coord_text(bit lon);
		string txt;
		case ($urandom_range(0, 11))
			0: txt = "";
			1: begin
				if (lon)
					txt = "18000.00000";
				else
					txt = "9000.00000";
			end
			2: begin
				if (lon)
					txt = "18000.00001";
				else
					txt = "9000.00001";
			end
			3: txt = {digits($urandom_range(6, 9)), ".", digits(3)};
			4: txt = {digits(lon ? 3 : 2), "59.99999"};
			5: txt = {digits(4), ".", digits(2), "x", digits(2)};
			6: txt = {digits(2), ".", digits(2), ".", digits(2)};
			7: txt = {".", digits($urandom_range(1, 9))};
			default: txt = {digits($urandom_range(lon ? 3 : 2, lon ? 5 : 4)), ".",
				digits($urandom_range(0, 8))};
		endcase
		return txt;
	endfunction

	function automatic string flag_text(string pos, string neg);
		string txt;
		case ($urandom_range(0, 7))
			0, 1, 2: txt = pos;
			3, 4, 5: txt = neg;
			6:       txt = "";
			default: txt = $sformatf("%c", $urandom_range(33, 126));
		endcase
		return txt;
	endfunction

	function automatic string rmc_sentence();
		string txt;
		string valid;
		string stamp;
		case ($urandom_range(0, 7))
			0:       valid = "V";
			1:       valid = "";
			2:       valid = "a";
			default: valid = "A";
		endcase
		if ($urandom_range(0, 4) == 0)
			stamp = "";
		else
			stamp = {digits(6), ".", digits(2)};
		txt = {"$GPRMC,", stamp, ",", valid, ",", coord_text(1'b0), ",",
			flag_text("N", "S"), ",", coord_text(1'b1), ",", flag_text("E", "W"), ","};
		if ($urandom_range(0, 1))
			txt = {txt, "010.5,,,A*3C"};
		return txt;
	endfunction

	function automatic void add_text(string txt, bit open, bit close);
		byte_word_t w;
		for (int k = 0; k < txt.len(); k++) begin
			w.ch    = txt[k];
			w.first = open && k == 0;
			w.last  = close && k == txt.len() - 1;
			stream.push_back(w);
		end
	endfunction

	function automatic void build_stream();
		string txt;
		int    base;
		// Idle byte with last while no sentence is open: ignored.
		stream.push_back('{ch: 8'hFF, first: 1'b0, last: 1'b1});
		// Header mismatch on the very first byte.
		stream.push_back('{ch: 8'h00, first: 1'b1, last: 1'b0});
		// Short header closed by last.
		add_text("$G", 1'b1, 1'b1);
		// Open sentence dropped by a restart, then an empty validity field.
		add_text("$GP", 1'b1, 1'b0);
		add_text("$GPRMC,,,", 1'b1, 1'b0);
		// Saturated coordinates, both negated.
		add_text("$GPRMC,,A,9999,S,99999,W,", 1'b1, 1'b0);
		// Random part.
		while (stream.size() < 1920) begin
			case ($urandom_range(0, 9))
				7: begin
					// Truncated sentence, closed by last or dropped by the next restart.
					txt = rmc_sentence();
					add_text(txt.substr(0, $urandom_range(0, txt.len() - 1)), 1'b1,
						1'($urandom_range(0, 1)));
				end
				8: begin
					// One header byte replaced by a random byte.
					base = stream.size();
					add_text(rmc_sentence(), 1'b1, 1'b1);
					stream[base + $urandom_range(0, 5)].ch = 8'($urandom_range(0, 255));
				end
				9: begin
					repeat ($urandom_range(1, 8))
						stream.push_back('{ch: 8'($urandom_range(0, 255)),
							first: 1'($urandom_range(0, 1)), last: 1'($urandom_range(0, 1))});
				end
				default: add_text(rmc_sentence(), 1'b1, 1'b1);
			endcase
		end
	endfunction

	// Byte words go out with random gaps; the final stretch runs without gaps.
	task automatic send_stream();
		int gap;
		for (int i = 0; i < stream.size(); i++) begin
			calm = (i + 300 >= stream.size());
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 15);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= stream[i].ch;
			s_tuser  <= stream[i].first;
			s_tlast  <= stream[i].last;
			do @(posedge clk); while (!s_tready);
		end
		s_tvalid <= 1'b0;
	endtask

	// Result words are taken with random stall bursts until the final stretch.
	initial begin
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		build_stream();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_stream();
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** nmea_rmc_position_parser: PASSED **");
		else
			$display("** nmea_rmc_position_parser: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** nmea_rmc_position_parser: FAILED **");
		$finish;
	end

endmodule
